[rtl/core/hclp_pkg.sv]
// Types, constants and the per-byte update function of the HTTP response
// Content-Length parser. Used by the parser top level and its checker.
package hclp_pkg;

  localparam int unsigned KEY_LEN = 14;
  localparam logic [13:0] STATUS_CAP = 14'd1000;
  localparam logic [34:0] MAG_CAP = 35'd2147483648;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    OUT_FOUND     = 2'd0,
    OUT_ENDED     = 2'd1,
    OUT_BAD_STAT  = 2'd2,
    OUT_MALFORMED = 2'd3
  } outcome_t;

  typedef enum logic [9:0] {
    PH_SL_PRE     = 10'b00_0000_0001,
    PH_SL_BLANK   = 10'b00_0000_0010,
    PH_SL_DIGITS  = 10'b00_0000_0100,
    PH_SL_REST    = 10'b00_0000_1000,
    PH_LINE_START = 10'b00_0001_0000,
    PH_NAME       = 10'b00_0010_0000,
    PH_VAL_PRE    = 10'b00_0100_0000,
    PH_VAL_NUM    = 10'b00_1000_0000,
    PH_SKIP       = 10'b01_0000_0000,
    PH_DONE       = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [9:0]  status_accum;
    logic [3:0]  name_idx;
    logic        name_ok;
    logic        blank_after;
    logic        has_content;
    logic [31:0] value_accum;
    logic        value_neg;
  } st_t;

  typedef struct packed {
    st_t         st;
    logic        fire;
    outcome_t    outcome;
    logic [31:0] len;
  } step_t;

  localparam st_t ST_RESET = '{
    phase: PH_SL_PRE, status_accum: 10'd0, name_idx: 4'd0, name_ok: 1'b1,
    blank_after: 1'b0, has_content: 1'b0, value_accum: 32'd0, value_neg: 1'b0
  };

  function automatic logic [7:0] key_char(logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = 8'h43; // C
      4'd1:    k = 8'h6F; // o
      4'd2:    k = 8'h6E; // n
      4'd3:    k = 8'h74; // t
      4'd4:    k = 8'h65; // e
      4'd5:    k = 8'h6E; // n
      4'd6:    k = 8'h74; // t
      4'd7:    k = 8'h2D; // -
      4'd8:    k = 8'h4C; // L
      4'd9:    k = 8'h65; // e
      4'd10:   k = 8'h6E; // n
      4'd11:   k = 8'h67; // g
      4'd12:   k = 8'h74; // t
      4'd13:   k = 8'h68; // h
      default: k = CH_NUL;
    endcase
    return k;
  endfunction

  function automatic step_t emit(step_t r, outcome_t oc, logic [31:0] len);
    step_t o;
    o = r;
    o.fire = 1'b1;
    o.outcome = oc;
    o.len = len;
    o.st.phase = PH_DONE;
    return o;
  endfunction

  function automatic step_t emit_found(step_t r);
    logic [31:0] len;
    if (r.st.value_neg) begin
      len = 32'd0 - r.st.value_accum;
    end else begin
      len = (r.st.value_accum > POS_MAX) ? POS_MAX : r.st.value_accum;
    end
    return emit(r, OUT_FOUND, len);
  endfunction

  function automatic st_t start_line(st_t s);
    st_t o;
    o = s;
    o.phase = PH_LINE_START;
    o.name_idx = 4'd0;
    o.name_ok = 1'b1;
    o.blank_after = 1'b0;
    o.has_content = 1'b0;
    return o;
  endfunction

  // One byte of the header name; never called with a line-end byte.
  function automatic st_t name_char(st_t s, logic [7:0] c);
    st_t o;
    logic blank;
    o = s;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    o.phase = PH_NAME;
    if (c == CH_COLON) begin
      o.name_ok = s.name_ok && s.has_content && (s.name_idx == 4'(KEY_LEN));
      o.value_accum = 32'd0;
      o.value_neg = 1'b0;
      o.phase = PH_VAL_PRE;
    end else if (blank) begin
      if (s.has_content) begin
        o.blank_after = 1'b1;
      end
    end else begin
      if (s.blank_after) begin
        o.name_ok = 1'b0;
      end
      o.has_content = 1'b1;
      if ((s.name_idx >= 4'(KEY_LEN)) || (key_char(s.name_idx) != c)) begin
        o.name_ok = 1'b0;
      end
      if (s.name_idx != 4'd15) begin
        o.name_idx = s.name_idx + 4'd1;
      end
    end
    return o;
  endfunction

  function automatic step_t feed(st_t s, logic [7:0] c);
    step_t r;
    logic eol, blank, digit;
    logic [3:0] d;
    logic [13:0] sa;
    logic [34:0] m;
    r.st = s;
    r.fire = 1'b0;
    r.outcome = OUT_FOUND;
    r.len = 32'd0;
    eol = (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
    blank = (c == CH_SPACE) || (c == CH_TAB);
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = 4'(c - CH_ZERO);
    sa = {4'd0, s.status_accum} * 14'd10 + {10'd0, d};
    m = {3'd0, s.value_accum} * 35'd10 + {31'd0, d};
    case (s.phase)
      PH_SL_PRE: begin
        if (c == CH_SPACE) begin
          r.st.phase = PH_SL_BLANK;
        end else if (eol) begin
          r = emit(r, OUT_BAD_STAT, 32'd0);
        end
      end
      PH_SL_BLANK: begin
        if (!blank) begin
          if (!digit) begin
            r = emit(r, OUT_BAD_STAT, 32'd0);
          end else begin
            r.st.status_accum = {6'd0, d};
            r.st.phase = PH_SL_DIGITS;
          end
        end
      end
      PH_SL_DIGITS: begin
        if (digit) begin
          r.st.status_accum = (sa > STATUS_CAP) ? 10'(STATUS_CAP) : sa[9:0];
        end else if ((s.status_accum < 10'd100) || (s.status_accum > 10'd999)) begin
          r = emit(r, OUT_BAD_STAT, 32'd0);
        end else if (c == CH_LF) begin
          r.st = start_line(s);
        end else if (c == CH_NUL) begin
          r = emit(r, OUT_ENDED, 32'd0);
        end else begin
          r.st.phase = PH_SL_REST;
        end
      end
      PH_SL_REST, PH_SKIP: begin
        if (c == CH_LF) begin
          r.st = start_line(s);
        end else if (c == CH_NUL) begin
          r = emit(r, OUT_ENDED, 32'd0);
        end
      end
      PH_LINE_START: begin
        if (eol) begin
          r = emit(r, OUT_ENDED, 32'd0);
        end else begin
          r.st = name_char(s, c);
        end
      end
      PH_NAME: begin
        if (eol) begin
          r = emit(r, OUT_MALFORMED, 32'd0);
        end else begin
          r.st = name_char(s, c);
        end
      end
      PH_VAL_PRE: begin
        if (blank) begin
          r.st = s;
        end else if (c == CH_NUL) begin
          r = emit(r, OUT_MALFORMED, 32'd0);
        end else if (!s.name_ok) begin
          if (c == CH_LF) begin
            r.st = start_line(s);
          end else begin
            r.st.phase = PH_SKIP;
          end
        end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
          r.st.value_neg = (c == CH_MINUS);
          r.st.phase = PH_VAL_NUM;
        end else if (!digit) begin
          r = emit_found(r);
        end else begin
          // The accumulator was cleared at the colon, so the first digit is the value.
          r.st.value_accum = {28'd0, d};
          r.st.phase = PH_VAL_NUM;
        end
      end
      PH_VAL_NUM: begin
        if (digit) begin
          r.st.value_accum = (m > MAG_CAP) ? 32'(MAG_CAP) : m[31:0];
        end else begin
          r = emit_found(r);
        end
      end
      PH_DONE: begin
        r.st = s;
      end
      default: begin
        r.st = s;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/http_content_length_parser.sv]
// HTTP response parser top level: status code and Content-Length extraction.
// Depends on hclp_pkg for the state type and the per-byte update function.
//
//   channel   signals                                  direction
//   input     in_valid, in_ready, data_byte, last      into the block
//   result    out_valid, out_ready, outcome,           out of the block
//             status_num, content_length
//
// One byte per unstalled cycle; the parse state updates in the same cycle.
// A result word appears in the output register the cycle after its byte.
// The input stalls only while a result word sits unaccepted in that register.
// Reset (rst, synchronous) readies the parser for the start of a response,
// as does every byte marked last.
module http_content_length_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         outcome,
  output logic [9:0]         status_num,
  output logic signed [31:0] content_length
);

  hclp_pkg::st_t   st;
  hclp_pkg::st_t   st_next;
  hclp_pkg::step_t r_byte;
  hclp_pkg::step_t r_end;
  logic            accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    r_byte = hclp_pkg::feed(st, data_byte);
    // The end of the buffer acts as a zero byte after the last byte.
    if (!r_byte.fire && last) begin
      r_end = hclp_pkg::feed(r_byte.st, hclp_pkg::CH_NUL);
    end else begin
      r_end = r_byte;
    end
    st_next = last ? hclp_pkg::ST_RESET : r_end.st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= hclp_pkg::ST_RESET;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (accept && r_end.fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && r_end.fire) begin
      outcome <= r_end.outcome;
      status_num <= r_end.st.status_accum;
      content_length <= (r_end.outcome == hclp_pkg::OUT_FOUND) ? r_end.len : 32'hFFFF_FFFF;
    end
  end

endmodule

[rtl/core/hclp_checker.sv]
// Port-level checker for the HTTP Content-Length parser, bound to its top level.
// Depends on hclp_pkg for the outcome codes.
module hclp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         outcome,
  input logic [9:0]         status_num,
  input logic signed [31:0] content_length
);

  // A stalled result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome) &&
      $stable(status_num) && $stable(content_length))
    else $error("result word changed while stalled");

  // A waiting result word blocks new input bytes.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while result word is stalled");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome != hclp_pkg::OUT_FOUND) |-> content_length == -32'sd1)
    else $error("length not -1 on an outcome other than found");

  // Getting past the status line needs a code from 100 to 999.
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (outcome != hclp_pkg::OUT_BAD_STAT) |->
      (status_num >= 10'd100) && (status_num <= 10'd999))
    else $error("header outcome with an invalid status code");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_num <= 10'd1000)
    else $error("status code above saturation");

endmodule

bind http_content_length_parser hclp_checker u_hclp_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .outcome        (outcome),
  .status_num     (status_num),
  .content_length (content_length)
);

[sim/tb_http_content_length_parser.sv]
`timescale 1ns / 100ps
// Self-checking testbench for http_content_length_parser: random and directed HTTP
// responses are fed byte by byte and every result word is checked against a
// built-in scanner model. Depends on hclp_pkg and the parser top level.
module tb_http_content_length_parser;

  typedef struct packed {
    logic [7:0] b;
    logic       l;
  } byte_item_t;

  typedef struct packed {
    hclp_pkg::outcome_t oc;
    logic [9:0]         code;
    logic [31:0]        len;
  } verdict_t;

  localparam logic [8*hclp_pkg::KEY_LEN-1:0] KEY_TEXT = "Content-Length";

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = 8'd0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         outcome;
  logic [9:0]         status_num;
  logic signed [31:0] content_length;

  byte_item_t  byte_q[$];
  verdict_t    verdict_q[$];
  logic [7:0]  resp_q[$];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned fails = 0;
  bit          calm = 1'b0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  verdict_t    want;

  // Scanner state mirrored from the parser.
  hclp_pkg::phase_t ph;
  logic [9:0]  code_acc;
  logic [3:0]  key_idx;
  logic        key_ok;
  logic        gap_in_name;
  logic        name_seen;
  logic [31:0] mag;
  logic        minus;
  bit          fired;

  http_content_length_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .outcome        (outcome),
    .status_num     (status_num),
    .content_length (content_length)
  );

  always #6 clk = ~clk;

  task automatic clear_scan();
    ph = hclp_pkg::PH_SL_PRE;
    code_acc = 10'd0;
    key_idx = 4'd0;
    key_ok = 1'b1;
    gap_in_name = 1'b0;
    name_seen = 1'b0;
    mag = 32'd0;
    minus = 1'b0;
  endtask

  task automatic open_line();
    ph = hclp_pkg::PH_LINE_START;
    key_idx = 4'd0;
    key_ok = 1'b1;
    gap_in_name = 1'b0;
    name_seen = 1'b0;
  endtask

  task automatic give_result(hclp_pkg::outcome_t oc, logic [31:0] len);
    verdict_q.push_back({oc, code_acc,
                         (oc == hclp_pkg::OUT_FOUND) ? len : 32'hFFFF_FFFF});
    ph = hclp_pkg::PH_DONE;
    fired = 1'b1;
  endtask

  task automatic give_length();
    logic [31:0] len;
    if (minus) begin
      len = 32'd0 - mag;
    end else begin
      len = (mag > hclp_pkg::POS_MAX) ? hclp_pkg::POS_MAX : mag;
    end
    give_result(hclp_pkg::OUT_FOUND, len);
  endtask

  // A name byte that is not a line end; the colon moves on to the value.
  task automatic name_byte(logic [7:0] c);
    ph = hclp_pkg::PH_NAME;
    if (c == hclp_pkg::CH_COLON) begin
      key_ok = key_ok && name_seen && (key_idx == 4'(hclp_pkg::KEY_LEN));
      mag = 32'd0;
      minus = 1'b0;
      ph = hclp_pkg::PH_VAL_PRE;
    end else if (c == hclp_pkg::CH_SPACE || c == hclp_pkg::CH_TAB) begin
      if (name_seen) begin
        gap_in_name = 1'b1;
      end
    end else begin
      if (gap_in_name) begin
        key_ok = 1'b0;
      end
      name_seen = 1'b1;
      if (key_idx >= 4'(hclp_pkg::KEY_LEN)) begin
        key_ok = 1'b0;
      end else if (KEY_TEXT[8 * (hclp_pkg::KEY_LEN - 1 - key_idx) +: 8] != c) begin
        key_ok = 1'b0;
      end
      if (key_idx != 4'd15) begin
        key_idx = key_idx + 4'd1;
      end
    end
  endtask

  task automatic scan_byte(logic [7:0] c);
    logic        blank;
    logic        eol;
    logic        dig;
    logic [3:0]  d;
    int unsigned sum;
    logic [63:0] prod;
    blank = (c == hclp_pkg::CH_SPACE) || (c == hclp_pkg::CH_TAB);
    eol = (c == hclp_pkg::CH_CR) || (c == hclp_pkg::CH_LF) || (c == hclp_pkg::CH_NUL);
    dig = (c >= hclp_pkg::CH_ZERO) && (c <= hclp_pkg::CH_NINE);
    d = c[3:0];
    case (ph)
      hclp_pkg::PH_SL_PRE: begin
        if (c == hclp_pkg::CH_SPACE) begin
          ph = hclp_pkg::PH_SL_BLANK;
        end else if (eol) begin
          give_result(hclp_pkg::OUT_BAD_STAT, 32'd0);
        end
      end
      hclp_pkg::PH_SL_BLANK: begin
        if (!blank) begin
          if (dig) begin
            code_acc = {6'd0, d};
            ph = hclp_pkg::PH_SL_DIGITS;
          end else begin
            give_result(hclp_pkg::OUT_BAD_STAT, 32'd0);
          end
        end
      end
      hclp_pkg::PH_SL_DIGITS: begin
        if (dig) begin
          sum = code_acc * 10 + d;
          code_acc = (sum > 1000) ? 10'd1000 : sum[9:0];
        end else if (code_acc < 10'd100 || code_acc > 10'd999) begin
          give_result(hclp_pkg::OUT_BAD_STAT, 32'd0);
        end else if (c == hclp_pkg::CH_LF) begin
          open_line();
        end else if (c == hclp_pkg::CH_NUL) begin
          give_result(hclp_pkg::OUT_ENDED, 32'd0);
        end else begin
          ph = hclp_pkg::PH_SL_REST;
        end
      end
      hclp_pkg::PH_SL_REST, hclp_pkg::PH_SKIP: begin
        if (c == hclp_pkg::CH_LF) begin
          open_line();
        end else if (c == hclp_pkg::CH_NUL) begin
          give_result(hclp_pkg::OUT_ENDED, 32'd0);
        end
      end
      hclp_pkg::PH_LINE_START: begin
        if (eol) begin
          give_result(hclp_pkg::OUT_ENDED, 32'd0);
        end else begin
          name_byte(c);
        end
      end
      hclp_pkg::PH_NAME: begin
        if (eol) begin
          give_result(hclp_pkg::OUT_MALFORMED, 32'd0);
        end else begin
          name_byte(c);
        end
      end
      hclp_pkg::PH_VAL_PRE: begin
        if (!blank) begin
          if (c == hclp_pkg::CH_NUL) begin
            give_result(hclp_pkg::OUT_MALFORMED, 32'd0);
          end else if (!key_ok) begin
            if (c == hclp_pkg::CH_LF) begin
              open_line();
            end else begin
              ph = hclp_pkg::PH_SKIP;
            end
          end else if (c == hclp_pkg::CH_PLUS || c == hclp_pkg::CH_MINUS) begin
            minus = (c == hclp_pkg::CH_MINUS);
            ph = hclp_pkg::PH_VAL_NUM;
          end else if (!dig) begin
            give_length();
          end else begin
            mag = {28'd0, d};
            ph = hclp_pkg::PH_VAL_NUM;
          end
        end
      end
      hclp_pkg::PH_VAL_NUM: begin
        if (dig) begin
          prod = {32'd0, mag} * 64'd10 + {60'd0, d};
          mag = (prod > 64'h8000_0000) ? 32'h8000_0000 : prod[31:0];
        end else begin
          give_length();
        end
      end
      default: begin
      end
    endcase
  endtask

  // The end of the buffer counts as a zero byte when nothing was reported yet.
  task automatic take_byte(logic [7:0] b, logic l);
    fired = 1'b0;
    if (ph != hclp_pkg::PH_DONE) begin
      scan_byte(b);
      if (!fired && l) begin
        scan_byte(hclp_pkg::CH_NUL);
      end
    end
    if (l) begin
      clear_scan();
    end
  endtask

  // Byte driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        take_byte(data_byte, last);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          {data_byte, last} <= byte_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          $error("unexpected result word: outcome %0d, status_num %0d, content_length %0d",
                 outcome, status_num, content_length);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (outcome !== want.oc) begin
            $error("outcome: expected %0d, got %0d", want.oc, outcome);
            fails++;
          end
          if (status_num !== want.code) begin
            $error("status_num: expected %0d, got %0d", want.code, status_num);
            fails++;
          end
          if (content_length !== want.len) begin
            $error("content_length: expected %0d, got %0d", $signed(want.len),
                   content_length);
            fails++;
          end
        end
      end
      // One long hold-off lets the result register fill and stall the input.
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 15) begin
        hold_done = 1'b1;
        hold_left = 299;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) begin
      resp_q.push_back(s[i]);
    end
  endtask

  task automatic add_blanks(int unsigned most);
    repeat ($urandom_range(0, most)) begin
      resp_q.push_back($urandom_range(0, 1) ? hclp_pkg::CH_SPACE : hclp_pkg::CH_TAB);
    end
  endtask

  task automatic add_digits(int unsigned n);
    repeat (n) begin
      resp_q.push_back(hclp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_sign();
    resp_q.push_back($urandom_range(0, 1) ? hclp_pkg::CH_PLUS : hclp_pkg::CH_MINUS);
  endtask

  task automatic add_header();
    string       nm;
    int unsigned pick;
    int unsigned pos;
    int unsigned op;
    nm = "Content-Length";
    add_blanks(1);
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      add_str(nm);
    end else if (pick < 7) begin
      // Near misses: a dropped letter, a flipped case bit, an inner blank, a suffix.
      pos = $urandom_range(0, hclp_pkg::KEY_LEN - 1);
      op = $urandom_range(0, 3);
      for (int i = 0; i < hclp_pkg::KEY_LEN; i++) begin
        if (op == 2 && i == pos) begin
          resp_q.push_back(hclp_pkg::CH_SPACE);
        end
        if (op == 1 && i == pos) begin
          resp_q.push_back(nm[i] ^ 8'h20);
        end else if (!(op == 0 && i == pos)) begin
          resp_q.push_back(nm[i]);
        end
      end
      if (op == 3) begin
        add_str("s");
      end
    end else if (pick == 7) begin
      add_str("Host");
    end else if (pick == 8) begin
      add_str("X-Len");
    end
    add_blanks(1);
    if ($urandom_range(0, 11) != 0) begin
      resp_q.push_back(hclp_pkg::CH_COLON);
    end
    add_blanks(2);
    case ($urandom_range(0, 9))
      0: begin
      end
      1: add_str("chunked");
      2: add_sign();
      3: begin
        add_sign();
        add_digits($urandom_range(10, 14));
      end
      4: begin
        if ($urandom_range(0, 2) != 0) begin
          add_sign();
        end
        case ($urandom_range(0, 3))
          0: add_str("2147483647");
          1: add_str("2147483648");
          2: add_str("4294967295");
          default: add_str("4294967296");
        endcase
      end
      default: begin
        if ($urandom_range(0, 3) == 0) begin
          add_sign();
        end
        add_digits($urandom_range(1, 6));
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      add_str(" x");
    end
    if ($urandom_range(0, 3) == 0) begin
      add_str("\n");
    end else begin
      add_str("\r\n");
    end
  endtask

  task automatic build_response();
    int unsigned n;
    resp_q.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        resp_q.push_back(8'($urandom));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: add_str("HTTP/1.1");
        1: add_str("H/1");
        2: begin
        end
        default: begin
          repeat ($urandom_range(1, 3)) begin
            resp_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
          end
        end
      endcase
      if ($urandom_range(0, 15) != 0) begin
        resp_q.push_back(hclp_pkg::CH_SPACE);
      end
      add_blanks(2);
      case ($urandom_range(0, 9))
        0: begin
        end
        1: add_digits($urandom_range(1, 5));
        2: begin
          case ($urandom_range(0, 3))
            0: add_str("99");
            1: add_str("100");
            2: add_str("999");
            default: add_str("1000");
          endcase
        end
        default: add_str($sformatf("%0d", $urandom_range(100, 599)));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        add_str(" OK");
      end
      case ($urandom_range(0, 5))
        0: add_str("\n");
        1: add_str("\t\n");
        default: add_str("\r\n");
      endcase
      repeat ($urandom_range(0, 3)) begin
        add_header();
      end
      if ($urandom_range(0, 3) != 0) begin
        add_str("\r\n");
      end
      repeat ($urandom_range(0, 3)) begin
        resp_q.push_back(8'($urandom));
      end
      // Broken responses: cut short, or one byte overwritten.
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, resp_q.size());
        resp_q = resp_q[0:n-1];
      end
      if ($urandom_range(0, 7) == 0) begin
        resp_q[$urandom_range(0, resp_q.size() - 1)] =
          $urandom_range(0, 1) ? hclp_pkg::CH_NUL : 8'($urandom);
      end
    end
  endtask

  // The final byte of each response carries the last flag.
  task automatic queue_response();
    foreach (resp_q[i]) begin
      byte_q.push_back({resp_q[i], i == resp_q.size() - 1});
    end
    n_queued += resp_q.size();
  endtask

  task automatic drain();
    while (n_accepted != n_queued || verdict_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned total;
    clear_scan();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    resp_q = {hclp_pkg::CH_NUL};
    queue_response();
    resp_q = {8'hFF};
    queue_response();
    resp_q.delete();
    add_str(" \t9999");
    queue_response();
    resp_q.delete();
    add_str(" 204\n\n");
    queue_response();
    resp_q.delete();
    add_str(" 100\nX\n");
    queue_response();
    drain();

    total = 0;
    while (total < 900) begin
      build_response();
      total += resp_q.size();
      queue_response();
    end
    drain();
    while (total < 1750) begin
      build_response();
      total += resp_q.size();
      queue_response();
    end
    while (byte_q.size() != 0) begin
      @(posedge clk);
    end
    calm = 1'b1;
    while (total < 1950) begin
      build_response();
      total += resp_q.size();
      queue_response();
    end
    drain();
    repeat (20) @(posedge clk);

    if (fails == 0 && verdict_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
